// ----- rtl/iph_pkg.sv -----
// shared constants for the indexed pairing heap
package iph_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int ID_W     = 10;
  localparam int KEY_IN_W = 32;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_UPD  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADID = 2'd2;

endpackage

// ----- rtl/indexed_pairing_heap_top.sv -----
// indexed pairing heap: node memories, op sequencer and meld unit
// push and decrease-key meld the node into the root when there is one and it is not the node;
//   pop of a leaf root empties the heap and a lone child becomes the root; else the children
//   are melded in pairs left to right, an odd child is stacked alone, and a right-to-left pass
//   melds the stack into the new root; one request at a time, the next taken the cycle after
//   the result is registered; the result register waits while out_stall holds the previous one
// reset clears control state, then a sweep clears membership of every entry, in_stall high
module indexed_pairing_heap_top #(
  parameter int CAPACITY  = iph_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = iph_pkg::KEY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [iph_pkg::OP_W-1:0]     op,
  input  logic [iph_pkg::ID_W-1:0]     node_id,
  input  logic [iph_pkg::KEY_IN_W-1:0] key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [iph_pkg::ID_W-1:0]     popped_id,
  output logic [iph_pkg::STAT_W-1:0]   status,
  output logic                        heap_empty
);

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = IW + 1;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_CHK2  = 5'd3;
  localparam logic [4:0] S_ROOT  = 5'd4;
  localparam logic [4:0] S_RX    = 5'd5;
  localparam logic [4:0] S_RY    = 5'd6;
  localparam logic [4:0] S_RY2   = 5'd7;
  localparam logic [4:0] S_RPUSH = 5'd8;
  localparam logic [4:0] S_MRD   = 5'd9;
  localparam logic [4:0] S_MJ    = 5'd10;
  localparam logic [4:0] S_MRET  = 5'd11;
  localparam logic [4:0] S_JA    = 5'd12;
  localparam logic [4:0] S_JB    = 5'd13;
  localparam logic [4:0] S_JW1   = 5'd14;
  localparam logic [4:0] S_JW2   = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;

  // node memories
  logic [KEY_WIDTH-1:0] key_mem [CAPACITY];
  logic [LW-1:0]        fc_mem  [CAPACITY];
  logic [LW-1:0]        ns_mem  [CAPACITY];
  logic [LW-1:0]        bl_mem  [CAPACITY];
  logic                 ih_mem  [CAPACITY];
  logic [LW-1:0]        st_mem  [CAPACITY];

  logic [KEY_WIDTH-1:0] rd_key;
  logic [LW-1:0]        rd_fc, rd_ns, rd_bl, rd_st;
  logic                 rd_ih;
  logic [IW-1:0]        raddr, st_raddr;

  logic                 key_we, fc_we, ns_we, bl_we, ih_we, st_we;
  logic [IW-1:0]        key_wa, fc_wa, ns_wa, bl_wa, ih_wa, st_wa;
  logic [KEY_WIDTH-1:0] key_wd;
  logic [LW-1:0]        fc_wd, ns_wd, bl_wd, st_wd;
  logic                 ih_wd;

  logic [4:0]           state, jret;
  logic [IW-1:0]        clr_cnt;
  logic [iph_pkg::OP_W-1:0] op_r;
  logic [iph_pkg::ID_W-1:0] id_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [LW-1:0]        root, head, regx, regy, acc, depth;
  logic                 first;
  logic [LW-1:0]        ja, jb, jres, jwin, jlose, jfcw, fca;
  logic [KEY_WIDTH-1:0] ka;
  logic [iph_pkg::STAT_W-1:0] stat_r;
  logic [iph_pkg::ID_W-1:0]   pop_r;

  logic                 id_ok, present, id_is_root, a_wins;
  logic [IW-1:0]        id_idx, link_p;
  logic [LW-1:0]        win_c, lose_c, fcw_c;

  assign id_ok      = 32'(id_r) < CAPACITY;
  assign id_idx     = IW'(id_r);
  assign present    = id_ok && rd_ih;
  assign id_is_root = {1'b0, id_idx} == root;
  assign link_p     = rd_bl[LW-1:1];
  assign a_wins     = ka < rd_key;
  assign win_c      = a_wins ? ja : jb;
  assign lose_c     = a_wins ? jb : ja;
  assign fcw_c      = a_wins ? fca : rd_fc;

  assign in_stall = state != S_IDLE;

  // read address selection
  always_comb begin
    raddr    = '0;
    st_raddr = IW'(depth - LW'(2));
    case (state)
      S_CHK:   raddr = (op_r == iph_pkg::OP_POP) ? IW'(root) : id_idx;
      S_RX:    raddr = IW'(head);
      S_RY:    raddr = IW'(rd_ns);
      S_JA:    raddr = IW'(ja);
      S_JB:    raddr = IW'(jb);
      default: raddr = '0;
    endcase
  end

  // write ports
  always_comb begin
    key_we = 1'b0; key_wa = id_idx; key_wd = key_r;
    fc_we = 1'b0;  fc_wa = id_idx;  fc_wd = NIL;
    ns_we = 1'b0;  ns_wa = id_idx;  ns_wd = NIL;
    bl_we = 1'b0;  bl_wa = id_idx;  bl_wd = rd_bl;
    ih_we = 1'b0;  ih_wa = id_idx;  ih_wd = 1'b0;
    st_we = 1'b0;  st_wa = IW'(depth); st_wd = regx;
    case (state)
      S_CLR: begin
        ih_we = 1'b1;
        ih_wa = clr_cnt;
      end
      S_CHK2: begin
        if (op_r == iph_pkg::OP_PUSH && id_ok && !rd_ih) begin
          ih_we = 1'b1; ih_wd = 1'b1;
          key_we = 1'b1;
          fc_we = 1'b1;
          ns_we = 1'b1;
        end else if (op_r == iph_pkg::OP_POP && root != NIL) begin
          ih_we = 1'b1;
          ih_wa = IW'(root);
        end else if (op_r == iph_pkg::OP_UPD && present) begin
          key_we = 1'b1;
          if (!id_is_root) begin
            // splice the node out of the chain that points at it
            if (32'(link_p) < CAPACITY) begin
              if (!rd_bl[0]) begin
                fc_we = 1'b1; fc_wa = link_p; fc_wd = rd_ns;
              end else begin
                ns_we = 1'b1; ns_wa = link_p; ns_wd = rd_ns;
              end
            end
            if (rd_ns != NIL) begin
              bl_we = 1'b1; bl_wa = IW'(rd_ns);
            end
          end
        end
      end
      S_RY: begin
        if (!(first && rd_ns == NIL) && rd_ns == NIL && depth < NIL) begin
          st_we = 1'b1; st_wd = head;
        end
      end
      S_RPUSH: begin
        if (depth < NIL) begin
          st_we = 1'b1; st_wd = jres;
        end
      end
      S_JW1: begin
        ns_we = 1'b1; ns_wa = IW'(lose_c); ns_wd = fcw_c;
        bl_we = 1'b1; bl_wa = IW'(lose_c); bl_wd = {IW'(win_c), 1'b0};
        fc_we = 1'b1; fc_wa = IW'(win_c);  fc_wd = lose_c;
      end
      S_JW2: begin
        ns_we = 1'b1; ns_wa = IW'(jwin);
        if (jfcw != NIL) begin
          bl_we = 1'b1; bl_wa = IW'(jfcw); bl_wd = {IW'(jlose), 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (fc_we)  fc_mem[fc_wa]   <= fc_wd;
    if (ns_we)  ns_mem[ns_wa]   <= ns_wd;
    if (bl_we)  bl_mem[bl_wa]   <= bl_wd;
    if (ih_we)  ih_mem[ih_wa]   <= ih_wd;
    if (st_we)  st_mem[st_wa]   <= st_wd;
    rd_key <= key_mem[raddr];
    rd_fc  <= fc_mem[raddr];
    rd_ns  <= ns_mem[raddr];
    rd_bl  <= bl_mem[raddr];
    rd_ih  <= ih_mem[raddr];
    rd_st  <= st_mem[st_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      root      <= NIL;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IW'(CAPACITY - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= op;
            id_r  <= node_id;
            key_r <= KEY_WIDTH'(key);
            state <= S_CHK;
          end
        end
        S_CHK: begin
          stat_r <= iph_pkg::ST_OK;
          pop_r  <= '0;
          state  <= S_CHK2;
        end
        S_CHK2: begin
          case (op_r)
            iph_pkg::OP_PUSH: begin
              if (!id_ok || rd_ih) begin
                stat_r <= iph_pkg::ST_BADID;
                state  <= S_FIN;
              end else if (root == NIL) begin
                root  <= {1'b0, id_idx};
                state <= S_FIN;
              end else begin
                ja <= root; jb <= {1'b0, id_idx}; jret <= S_ROOT; state <= S_JA;
              end
            end
            iph_pkg::OP_POP: begin
              if (root == NIL) begin
                stat_r <= iph_pkg::ST_EMPTY;
                state  <= S_FIN;
              end else begin
                pop_r <= iph_pkg::ID_W'(root);
                if (rd_fc == NIL) begin
                  root  <= NIL;
                  state <= S_FIN;
                end else begin
                  head  <= rd_fc;
                  first <= 1'b1;
                  depth <= '0;
                  state <= S_RX;
                end
              end
            end
            iph_pkg::OP_UPD: begin
              if (!present) begin
                stat_r <= iph_pkg::ST_BADID;
                state  <= S_FIN;
              end else if (!id_is_root) begin
                ja <= root; jb <= {1'b0, id_idx}; jret <= S_ROOT; state <= S_JA;
              end else begin
                state <= S_FIN;
              end
            end
            default: state <= S_FIN;
          endcase
        end
        S_ROOT: begin
          root  <= jres;
          state <= S_FIN;
        end
        S_RX: state <= S_RY;
        S_RY: begin
          first <= 1'b0;
          if (first && rd_ns == NIL) begin
            root  <= head;
            state <= S_FIN;
          end else if (rd_ns == NIL) begin
            // odd child left over goes on the stack alone
            if (depth < NIL) begin
              depth <= depth + 1'b1;
              acc   <= head;
            end
            state <= S_MRD;
          end else begin
            regx  <= head;
            regy  <= rd_ns;
            state <= S_RY2;
          end
        end
        S_RY2: begin
          head  <= rd_ns;
          ja    <= regy;
          jb    <= regx;
          jret  <= S_RPUSH;
          state <= S_JA;
        end
        S_RPUSH: begin
          if (depth < NIL) begin
            depth <= depth + 1'b1;
            acc   <= jres;
          end
          state <= (head != NIL) ? S_RX : S_MRD;
        end
        S_MRD: begin
          if (depth <= LW'(1)) begin
            root  <= acc;
            state <= S_FIN;
          end else begin
            depth <= depth - 1'b1;
            state <= S_MJ;
          end
        end
        S_MJ: begin
          ja    <= acc;
          jb    <= rd_st;
          jret  <= S_MRET;
          state <= S_JA;
        end
        S_MRET: begin
          acc   <= jres;
          state <= S_MRD;
        end
        S_JA: begin
          if (ja == NIL) begin
            jres <= jb; state <= jret;
          end else if (jb == NIL) begin
            jres <= ja; state <= jret;
          end else begin
            state <= S_JB;
          end
        end
        S_JB: begin
          ka    <= rd_key;
          fca   <= rd_fc;
          state <= S_JW1;
        end
        S_JW1: begin
          jwin  <= win_c;
          jlose <= lose_c;
          jfcw  <= fcw_c;
          state <= S_JW2;
        end
        S_JW2: begin
          jres  <= jwin;
          state <= jret;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            popped_id  <= pop_r;
            status     <= stat_r;
            heap_empty <= root == NIL;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !(out_valid && out_stall)) |=> heap_empty == ($past(root) == NIL))
    else $error("heap_empty does not match root");
  a_clr_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> in_stall)
    else $error("request taken during clearing sweep");
  a_join_win: assert property (@(posedge clk) disable iff (rst)
    state == S_JW2 |-> (jwin == ja || jwin == jb))
    else $error("meld winner is not an operand");
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && stat_r == iph_pkg::ST_EMPTY) |-> pop_r == '0)
    else $error("pop on empty heap reports an id");
`endif

endmodule
